// ===== design/grc_pkg.sv =====
// Shared types, codes and constants of the gate run coalescer.
`timescale 1ns / 1ps
package grc_pkg;

  localparam int AXIS_W        = 16;
  localparam int MASK_W        = 64;
  localparam int WORD_W        = 64;
  localparam int MASK_BITS_DEF = 64;
  localparam int AXIS_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_OTHER = 2'd0,
    OP_CNOT  = 2'd1,
    OP_CZ    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_MCX  = 2'd1,
    KIND_MCZ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [AXIS_W-1:0] axis;
    logic [MASK_W-1:0] mask;
    logic [WORD_W-1:0] word;
    logic              err;
    logic              last_step;
    logic              last_prog;
  } result_t;

  // Results caused by one accepted word: one or two.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } step_t;

endpackage

// ===== design/grc_channels.sv =====
// Valid/ready channel interfaces for instruction and result words.
`timescale 1ns / 1ps
interface grc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [grc_pkg::AXIS_W-1:0] control_axis;
  logic [grc_pkg::AXIS_W-1:0] target_axis;
  logic [grc_pkg::WORD_W-1:0] instruction_word;
  logic                      program_end;

  modport source (output valid, operation, control_axis, target_axis,
                  instruction_word, program_end, input ready);
  modport sink   (input valid, operation, control_axis, target_axis,
                  instruction_word, program_end, output ready);
endinterface

interface grc_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [grc_pkg::AXIS_W-1:0] shared_axis;
  logic [grc_pkg::MASK_W-1:0] axis_mask;
  logic [grc_pkg::WORD_W-1:0] original_word;
  logic                      axis_error;
  logic                      last_of_step;
  logic                      last_of_program;

  modport source (output valid, result_kind, shared_axis, axis_mask, original_word,
                  axis_error, last_of_step, last_of_program, input ready);
  modport sink   (input valid, result_kind, shared_axis, axis_mask, original_word,
                  axis_error, last_of_step, last_of_program, output ready);
endinterface

// ===== design/grc_front.sv =====
// Front end: classify each word, track the open run, build the step's results.
`timescale 1ns / 1ps
module grc_front #(
  parameter int MASK_BITS = grc_pkg::MASK_BITS_DEF,
  parameter int AXIS_BITS = grc_pkg::AXIS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  grc_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             push,
  output grc_pkg::step_t   step
);
  import grc_pkg::*;

  localparam int IDX_W = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

  logic                 run_open_r, run_open_nxt;
  logic                 run_class_r, run_class_nxt;
  logic [AXIS_BITS-1:0] run_axis_r, run_axis_nxt;
  logic [MASK_BITS-1:0] run_mask_r, run_mask_nxt;
  logic                 run_multi_r, run_multi_nxt;
  logic [WORD_W-1:0]    run_word_r, run_word_nxt;
  logic                 run_err_r, run_err_nxt;

  logic                 acc, is_gate, cls, match, prog_end;
  logic [AXIS_BITS-1:0] ctl, tgt, shared, vary;
  logic                 in_range;
  logic [MASK_BITS-1:0] vary_bit;
  logic                 a_valid, b_valid;
  result_t              res_a, res_b, res_pass;

  function automatic result_t flush_res(logic cls_i, logic [AXIS_BITS-1:0] axis_i,
                                        logic [MASK_BITS-1:0] mask_i, logic multi_i,
                                        logic [WORD_W-1:0] word_i, logic err_i);
    result_t r;
    r = '0;
    if (multi_i) begin
      r.kind = cls_i ? KIND_MCZ : KIND_MCX;
      r.axis = AXIS_W'(axis_i);
      r.mask = MASK_W'(mask_i);
      r.err  = err_i;
    end else begin
      r.kind = KIND_WORD;
      r.word = word_i;
    end
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign prog_end    = in_ch.program_end;

  always_comb begin
    ctl      = in_ch.control_axis[AXIS_BITS-1:0];
    tgt      = in_ch.target_axis[AXIS_BITS-1:0];
    is_gate  = (in_ch.operation == OP_CNOT) || (in_ch.operation == OP_CZ);
    cls      = (in_ch.operation == OP_CZ);
    shared   = cls ? ctl : tgt;
    vary     = cls ? tgt : ctl;
    in_range = {1'b0, vary} < (AXIS_BITS+1)'(MASK_BITS);
    vary_bit = in_range ? ({{(MASK_BITS-1){1'b0}}, 1'b1} << vary[IDX_W-1:0]) : '0;
    match    = run_open_r && (run_class_r == cls) && (run_axis_r == shared);

    // Run state after this word, before any program-end flush.
    run_open_nxt  = run_open_r;
    run_class_nxt = run_class_r;
    run_axis_nxt  = run_axis_r;
    run_mask_nxt  = run_mask_r;
    run_multi_nxt = run_multi_r;
    run_word_nxt  = run_word_r;
    run_err_nxt   = run_err_r;
    if (is_gate) begin
      if (match) begin
        run_mask_nxt  = run_mask_r | vary_bit;
        run_err_nxt   = run_err_r | !in_range;
        run_multi_nxt = 1'b1;
      end else begin
        run_open_nxt  = 1'b1;
        run_class_nxt = cls;
        run_axis_nxt  = shared;
        run_mask_nxt  = vary_bit;
        run_err_nxt   = !in_range;
        run_multi_nxt = 1'b0;
        run_word_nxt  = in_ch.instruction_word;
      end
    end

    // First candidate: the old run, closed by a break or a non-gate word.
    a_valid = run_open_r && !(is_gate && match);
    res_a   = flush_res(run_class_r, run_axis_r, run_mask_r, run_multi_r,
                        run_word_r, run_err_r);

    // Second candidate: the updated run on program end, or the passed word.
    res_pass      = '0;
    res_pass.kind = KIND_WORD;
    res_pass.word = in_ch.instruction_word;
    b_valid = is_gate ? prog_end : 1'b1;
    res_b   = is_gate ? flush_res(run_class_nxt, run_axis_nxt, run_mask_nxt,
                                  run_multi_nxt, run_word_nxt, run_err_nxt)
                      : res_pass;

    step = '0;
    push = acc && (a_valid || b_valid);
    if (a_valid && b_valid) begin
      step.two          = 1'b1;
      step.r0           = res_a;
      step.r1           = res_b;
      step.r1.last_step = 1'b1;
      step.r1.last_prog = prog_end;
    end else begin
      step.r0           = a_valid ? res_a : res_b;
      step.r0.last_step = 1'b1;
      step.r0.last_prog = prog_end;
    end

    // Close the run on program end or after a non-gate word.
    if (prog_end || !is_gate) begin
      run_open_nxt  = 1'b0;
      run_multi_nxt = 1'b0;
      run_mask_nxt  = '0;
      run_err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_class_r <= 1'b0;
      run_axis_r  <= '0;
      run_mask_r  <= '0;
      run_multi_r <= 1'b0;
      run_word_r  <= '0;
      run_err_r   <= 1'b0;
    end else if (acc) begin
      run_open_r  <= run_open_nxt;
      run_class_r <= run_class_nxt;
      run_axis_r  <= run_axis_nxt;
      run_mask_r  <= run_mask_nxt;
      run_multi_r <= run_multi_nxt;
      run_word_r  <= run_word_nxt;
      run_err_r   <= run_err_nxt;
    end
  end

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && prog_end |=> !run_open_r)
    else $error("run still open after program end");

  a_pass_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_gate |-> push)
    else $error("non-gate word produced no result");

  a_push_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc && !q_full)
    else $error("step pushed without an accepted word");

  a_two_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    push && step.two |-> run_open_r)
    else $error("two results with no open run");

endmodule

// ===== design/grc_step_fifo.sv =====
// Two-entry queue of steps between the front and back ends.
`timescale 1ns / 1ps
module grc_step_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  grc_pkg::step_t  push_step,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output grc_pkg::step_t  head_step
);
  import grc_pkg::*;

  step_t       slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_step  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== design/grc_back.sv =====
// Back end: drain each queued step one result at a time into the output register.
`timescale 1ns / 1ps
module grc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  grc_pkg::step_t  head_step,
  output logic            pop,
  grc_out_if.source       out_ch
);
  import grc_pkg::*;

  logic    idx_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    load;
  result_t cur;

  assign cur  = idx_r ? head_step.r1 : head_step.r0;
  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && (idx_r || !head_step.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= !pop;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= cur;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_res_r.kind;
  assign out_ch.shared_axis     = out_res_r.axis;
  assign out_ch.axis_mask       = out_res_r.mask;
  assign out_ch.original_word   = out_res_r.word;
  assign out_ch.axis_error      = out_res_r.err;
  assign out_ch.last_of_step    = out_res_r.last_step;
  assign out_ch.last_of_program = out_res_r.last_prog;

endmodule

// ===== design/gate_run_coalescer_top.sv =====
// Top level of the gate run coalescer: front end, step queue, back end.
`timescale 1ns / 1ps
// Path: a word accepted on the input is queued as a step, and its results leave from
//   the output register; a second result of the same word follows the first.
// Throughput: one word per cycle while the step queue has room; the output register
//   emits one result per cycle while ready; a break that passes or flushes gives two.
// Reset: synchronous, active low; closes the open run and empties the queue.
module gate_run_coalescer_top #(
  parameter int MASK_BITS = grc_pkg::MASK_BITS_DEF,
  parameter int AXIS_BITS = grc_pkg::AXIS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  grc_in_if.sink     in_ch,
  grc_out_if.source  out_ch
);
  import grc_pkg::*;

  // Steps built by the front end and held until the back end has sent them.
  logic  q_push, q_full, q_pop, q_head_valid;
  step_t q_push_step, q_head_step;

  // Classify each word, merge it into the open run, and build its results.
  grc_front #(
    .MASK_BITS (MASK_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push),
    .step   (q_push_step)
  );

  // Short queue so the input can keep flowing while results wait downstream.
  grc_step_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_step  (q_push_step),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_step  (q_head_step)
  );

  // Send the queued results in order, one result per cycle while the receiver is ready.
  grc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_step  (q_head_step),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/tb_gate_run_coalescer_top.sv =====
// Self-checking testbench for the gate run coalescer top level.
`timescale 1ns / 1ps
module tb_gate_run_coalescer_top;
  import grc_pkg::*;

  // Operation code 3 is unused; the block treats it as a plain word.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1450;

  typedef struct packed {
    logic [1:0]        op;
    logic [AXIS_W-1:0] ctl;
    logic [AXIS_W-1:0] tgt;
    logic [WORD_W-1:0] word;
    logic              last;
  } instr_t;

  logic clk;
  logic rst_n;

  grc_in_if  in_ch();
  grc_out_if out_ch();

  gate_run_coalescer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  instr_t  pending[$];    // words still to be offered
  result_t awaited[$];    // results predicted but not yet seen
  instr_t  on_bus;        // word currently offered on the input channel
  int      words_in;      // words accepted so far
  int      errors;
  int      hold_left;     // cycles left of the long receiver hold-off
  bit      hold_done;

  // Own copy of the open run.
  logic              run_live;
  logic              run_is_z;
  logic [AXIS_W-1:0] run_axis;
  logic [MASK_W-1:0] run_bits;
  logic              run_merged;
  logic [WORD_W-1:0] run_word;
  logic              run_overflow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Most gaps short, a few long; none at all while a steady stretch lasts.
  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_item(logic [1:0] op, logic [AXIS_W-1:0] ctl,
                          logic [AXIS_W-1:0] tgt, logic [WORD_W-1:0] word,
                          logic last);
    instr_t w;
    w.op   = op;
    w.ctl  = ctl;
    w.tgt  = tgt;
    w.word = word;
    w.last = last;
    pending = {pending, w};
  endtask

  // Fold one varying axis into the run; an axis beyond the mask only flags.
  function automatic void fold_axis(logic [AXIS_W-1:0] vary);
    if (vary < MASK_BITS_DEF) run_bits |= 64'd1 << vary;
    else run_overflow = 1'b1;
  endfunction

  // Close the open run and give back the result it stands for.
  function automatic result_t close_run();
    result_t r;
    r = '0;
    if (run_merged) begin
      r.kind = run_is_z ? KIND_MCZ : KIND_MCX;
      r.axis = run_axis;
      r.mask = run_bits;
      r.err  = run_overflow;
    end else begin
      r.kind = KIND_WORD;
      r.word = run_word;
    end
    run_live     = 1'b0;
    run_merged   = 1'b0;
    run_bits     = '0;
    run_overflow = 1'b0;
    return r;
  endfunction

  // Work out the results that one accepted word causes and queue them.
  task automatic coalesce_word(instr_t w);
    result_t           made[$];
    result_t           r;
    logic              as_z;
    logic [AXIS_W-1:0] shared;
    logic [AXIS_W-1:0] vary;
    if (w.op == OP_CNOT || w.op == OP_CZ) begin
      as_z   = (w.op == OP_CZ);
      shared = as_z ? w.ctl : w.tgt;
      vary   = as_z ? w.tgt : w.ctl;
      if (run_live && run_is_z == as_z && run_axis == shared) begin
        fold_axis(vary);
        run_merged = 1'b1;
      end else begin
        // Break the run: emit it first, then open a fresh one.
        if (run_live) made = {made, close_run()};
        run_live     = 1'b1;
        run_is_z     = as_z;
        run_axis     = shared;
        run_bits     = '0;
        run_overflow = 1'b0;
        run_merged   = 1'b0;
        run_word     = w.word;
        fold_axis(vary);
      end
    end else begin
      if (run_live) made = {made, close_run()};
      r      = '0;
      r.kind = KIND_WORD;
      r.word = w.word;
      made = {made, r};
    end
    if (w.last && run_live) made = {made, close_run()};
    if (made.size() > 0) begin
      made[made.size()-1].last_step = 1'b1;
      made[made.size()-1].last_prog = w.last;
    end
    foreach (made[i]) awaited = {awaited, made[i]};
  endtask

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  // Driver: offer queued words with random gaps; predict on each handshake.
  always @(posedge clk) begin : drive_proc
    int   send_gap;
    logic offer;
    offer = in_ch.valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
      run_live     = 1'b0;
      run_is_z     = 1'b0;
      run_axis     = '0;
      run_bits     = '0;
      run_merged   = 1'b0;
      run_word     = '0;
      run_overflow = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        coalesce_word(on_bus);
        words_in <= words_in + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          in_ch.operation        <= on_bus.op;
          in_ch.control_axis     <= on_bus.ctl;
          in_ch.target_axis      <= on_bus.tgt;
          in_ch.instruction_word <= on_bus.word;
          in_ch.program_end      <= on_bus.last;
          offer = 1'b1;
          // Steady stretches: every fourth block of words goes back to back.
          send_gap = pick_gap(((words_in / 128) % 4) == 1);
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Long hold-off: starve the output once so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 600) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    int      recv_gap;
    int      cycle_no;
    logic    take;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      cycle_no = 0;
    end else begin
      cycle_no++;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with nothing expected, kind %h word %h", $time,
                   out_ch.result_kind, out_ch.original_word);
          errors++;
        end else begin
          want = awaited.pop_front();
          report("result_kind", 64'(want.kind), 64'(out_ch.result_kind));
          report("shared_axis", 64'(want.axis), 64'(out_ch.shared_axis));
          report("axis_mask", want.mask, out_ch.axis_mask);
          report("original_word", want.word, out_ch.original_word);
          report("axis_error", 64'(want.err), 64'(out_ch.axis_error));
          report("last_of_step", 64'(want.last_step), 64'(out_ch.last_of_step));
          report("last_of_program", 64'(want.last_prog), 64'(out_ch.last_of_program));
        end
        recv_gap = pick_gap(((cycle_no / 200) % 5) == 2);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ch.ready <= take && (hold_left == 0);
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin : main_proc
    int                roll;
    int                len;
    logic [1:0]        op;
    logic [AXIS_W-1:0] shared;
    logic [AXIS_W-1:0] vary;
    logic              stop;

    errors   = 0;
    words_in = 0;
    rst_n    = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = OP_OTHER;
    in_ch.control_axis     = '0;
    in_ch.target_axis      = '0;
    in_ch.instruction_word = '0;
    in_ch.program_end      = 1'b0;
    out_ch.ready           = 1'b0;

    // Plain words at the extremes, and the unused code as a plain word.
    add_item(OP_OTHER, 16'hFFFF, 16'hFFFF, '1, 1'b0);
    add_item(OP_OTHER, 16'h0000, 16'h0000, '0, 1'b0);
    add_item(OP_SPARE, 16'h1234, 16'hFFFF, rand_word(), 1'b0);
    // Run of one gives back its word; then a run of one whose axis is beyond the mask.
    add_item(OP_CNOT, 16'd0, 16'd5, rand_word(), 1'b0);
    add_item(OP_OTHER, 16'd0, 16'd0, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'd100, 16'd9, rand_word(), 1'b0);
    add_item(OP_OTHER, 16'd0, 16'd0, rand_word(), 1'b0);
    // Merged controlled-NOT on the top target with axes beyond the mask.
    add_item(OP_CNOT, 16'd0, 16'hFFFF, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'd63, 16'hFFFF, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'd64, 16'hFFFF, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'hFFFF, 16'hFFFF, rand_word(), 1'b0);
    // Clean run, broken by a controlled-Z on the same axis number.
    add_item(OP_CNOT, 16'd1, 16'd7, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'd2, 16'd7, rand_word(), 1'b0);
    add_item(OP_CNOT, 16'd63, 16'd7, rand_word(), 1'b0);
    add_item(OP_CZ, 16'd7, 16'd0, rand_word(), 1'b0);
    add_item(OP_CZ, 16'd7, 16'd63, rand_word(), 1'b0);
    add_item(OP_CZ, 16'd7, 16'd64, rand_word(), 1'b0);
    // Change of shared control breaks the run; program end joins and flushes.
    add_item(OP_CZ, 16'd0, 16'd3, rand_word(), 1'b0);
    add_item(OP_CZ, 16'd0, 16'd4, rand_word(), 1'b1);
    // Plain word with program end while a run is open: two results.
    add_item(OP_CNOT, 16'd8, 16'd2, rand_word(), 1'b0);
    add_item(OP_OTHER, 16'd0, 16'd0, rand_word(), 1'b1);
    // Gate with program end and nothing open: opens and flushes at once.
    add_item(OP_CZ, 16'hFFFF, 16'd1, rand_word(), 1'b1);

    // Random part: mostly well-formed runs, some plain words, some noise.
    while (pending.size() < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        op     = $urandom_range(0, 1) ? OP_CNOT : OP_CZ;
        shared = ($urandom_range(0, 9) == 0) ? AXIS_W'($urandom)
                                              : AXIS_W'($urandom_range(0, 7));
        len    = $urandom_range(1, 6);
        repeat (len) begin
          vary = ($urandom_range(0, 7) == 0) ? AXIS_W'($urandom)
                                             : AXIS_W'($urandom_range(0, 63));
          stop = ($urandom_range(0, 29) == 0);
          if (op == OP_CNOT) add_item(op, vary, shared, rand_word(), stop);
          else add_item(op, shared, vary, rand_word(), stop);
        end
      end else if (roll < 85) begin
        op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_OTHER;
        add_item(op, AXIS_W'($urandom), AXIS_W'($urandom), rand_word(),
                 $urandom_range(0, 29) == 0);
      end else begin
        add_item(2'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), rand_word(),
                 $urandom_range(0, 19) == 0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every word accepted, every result seen, then a short settle.
    while (pending.size() > 0 || in_ch.valid) @(posedge clk);
    while (awaited.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
